// ----- hdl/wave_table_sound_channel_unit_defines.svh -----
// Assertion macros shared by the wave-table sound channel checker.
`ifndef WAVE_TABLE_SOUND_CHANNEL_UNIT_DEFINES_SVH
`define WAVE_TABLE_SOUND_CHANNEL_UNIT_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define WTSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define WTSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ----- hdl/wtsc_pkg.sv -----
// Types, codes and constants of the wave-table sound channel.
package wtsc_pkg;

    localparam int BANK_SAMPLES = 16;
    localparam int POS_W        = $clog2(BANK_SAMPLES);
    // Two banks of 4-bit samples, two samples per byte.
    localparam int RAM_BYTES    = BANK_SAMPLES;
    localparam int RAM_AW       = $clog2(RAM_BYTES);

    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(BANK_SAMPLES - 1);
    localparam logic [11:0]      PERIOD_BASE = 12'd2048;

    // Action codes.
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_LENGTH = 3'd1;
    localparam logic [2:0] ACT_REG_WR = 3'd2;
    localparam logic [2:0] ACT_REG_RD = 3'd3;
    localparam logic [2:0] ACT_RAM_WR = 3'd4;
    localparam logic [2:0] ACT_RAM_RD = 3'd5;

    // Register indexes.
    localparam logic [3:0] REG_CTRL    = 4'd0;
    localparam logic [3:0] REG_LENGTH  = 4'd1;
    localparam logic [3:0] REG_VOLUME  = 4'd2;
    localparam logic [3:0] REG_FREQ_LO = 4'd3;
    localparam logic [3:0] REG_FREQ_HI = 4'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] addr;
        logic [7:0] write_data;
    } t_wtsc_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] sample;
        logic       channel_on;
    } t_wtsc_out;

    // Volume code to multiplier; the result is later divided by four.
    function automatic logic [2:0] vol_factor(input logic [2:0] code);
        logic [2:0] f;
        case (code)
            3'd0:    f = 3'd0;
            3'd1:    f = 3'd4;
            3'd2:    f = 3'd2;
            3'd3:    f = 3'd1;
            default: f = 3'd3;
        endcase
        return f;
    endfunction

endpackage

// ----- hdl/wtsc_channel_ifs.sv -----
// Valid/ready stream interfaces for the input and result channels.
interface wtsc_in_if import wtsc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_wtsc_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface wtsc_out_if import wtsc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_wtsc_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/wave_table_sound_channel_unit.sv -----
// Top level of the wave-table sound channel: input register, step logic, result register.
//
//   channel   | direction | beat carries
//   ----------+-----------+--------------------------------------
//   i_item    | in        | action, addr, write_data
//   o_result  | out       | read_data, sample, channel_on
//
// One beat is accepted per cycle unless stalled; it passes the input, then the result register.
// Throughput is set by the single state-update stage between the input and result registers.
// A stalled result holds the result register; an empty input register still takes one more beat.
// Synchronous reset clears all channel state and the wave RAM.
module wave_table_sound_channel_unit import wtsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wtsc_in_if.sink     i_item,
    wtsc_out_if.source  o_result
);

    logic             r_in_valid;
    t_wtsc_in         r_in;
    logic             r_out_valid;
    t_wtsc_out        r_out;

    logic [7:0]       r_wave_ram [RAM_BYTES];
    logic             r_two_bank, n_two_bank;
    logic             r_bank_sel, n_bank_sel;
    logic             r_dac_on, n_dac_on;
    logic [7:0]       r_length_count, n_length_count;
    logic [2:0]       r_volume, n_volume;
    logic [10:0]      r_freq, n_freq;
    logic             r_length_en, n_length_en;
    logic             r_chan_en, n_chan_en;
    logic [3:0]       r_out_level, n_out_level;
    logic [POS_W-1:0] r_sample_pos, n_sample_pos;
    logic             r_play_bank, n_play_bank;
    logic [3:0]       r_held_sample, n_held_sample;
    logic [11:0]      r_period, n_period;

    logic             advance;
    logic             step;
    logic [RAM_AW-1:0] ram_idx;
    logic [7:0]       ram_byte;
    logic [3:0]       fetched;
    logic [11:0]      period_dec;
    logic [6:0]       level_prod;
    logic [7:0]       rd;
    t_wtsc_out        n_out;

    assign advance        = !r_out_valid || o_result.ready;
    assign step           = r_in_valid && advance;
    assign i_item.ready   = !r_in_valid || advance;
    assign o_result.valid = r_out_valid;
    assign o_result.payload = r_out;

    // A tick reads the byte holding the current sample; RAM reads use the bus address.
    assign ram_idx    = (r_in.action == ACT_TICK) ? {r_play_bank, r_sample_pos[POS_W-1:1]}
                                                  : r_in.addr[RAM_AW-1:0];
    assign ram_byte   = r_wave_ram[ram_idx];
    assign fetched    = r_sample_pos[0] ? ram_byte[7:4] : ram_byte[3:0];
    assign period_dec = r_period - 12'd1;
    assign level_prod = {3'b000, n_held_sample} * {4'b0000, vol_factor(r_volume)};

    always_comb begin
        n_two_bank     = r_two_bank;
        n_bank_sel     = r_bank_sel;
        n_dac_on       = r_dac_on;
        n_length_count = r_length_count;
        n_volume       = r_volume;
        n_freq         = r_freq;
        n_length_en    = r_length_en;
        n_chan_en      = r_chan_en;
        n_out_level    = r_out_level;
        n_sample_pos   = r_sample_pos;
        n_play_bank    = r_play_bank;
        n_held_sample  = r_held_sample;
        n_period       = r_period;
        rd             = 8'd0;

        unique case (r_in.action)
            ACT_TICK: begin
                if (r_period != 12'd0) begin
                    n_period = period_dec;
                    if (period_dec == 12'd0) begin
                        n_period      = PERIOD_BASE - {1'b0, r_freq};
                        n_held_sample = fetched;
                        n_sample_pos  = r_sample_pos + POS_W'(1);
                        if (r_sample_pos == POS_LAST) begin
                            n_play_bank = r_play_bank ^ r_two_bank;
                        end
                    end
                end
            end
            ACT_LENGTH: begin
                if (r_chan_en && r_length_en) begin
                    n_length_count = r_length_count + 8'd1;
                    if (r_length_count == 8'hff) begin
                        n_chan_en = 1'b0;
                    end
                end
            end
            ACT_REG_WR: begin
                unique case (r_in.addr)
                    REG_CTRL: begin
                        n_two_bank = r_in.write_data[5];
                        n_bank_sel = r_in.write_data[6];
                        n_dac_on   = r_in.write_data[7];
                        if (!r_in.write_data[7]) begin
                            n_chan_en = 1'b0;
                        end
                    end
                    REG_LENGTH: begin
                        n_length_count = r_in.write_data;
                    end
                    REG_VOLUME: begin
                        n_volume = r_in.write_data[7:5];
                    end
                    REG_FREQ_LO: begin
                        n_freq = {r_freq[10:8], r_in.write_data};
                    end
                    REG_FREQ_HI: begin
                        n_freq      = {r_in.write_data[2:0], r_freq[7:0]};
                        n_length_en = r_in.write_data[6];
                        // Trigger restarts playback with the frequency just written.
                        if (r_in.write_data[7]) begin
                            n_chan_en    = r_dac_on;
                            n_period     = PERIOD_BASE - {1'b0, n_freq};
                            n_sample_pos = '0;
                            n_play_bank  = r_two_bank ? 1'b0 : r_bank_sel;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ACT_REG_RD: begin
                unique case (r_in.addr)
                    REG_CTRL:    rd = {r_dac_on, r_bank_sel, r_two_bank, 5'd0};
                    REG_VOLUME:  rd = {r_volume, 5'd0};
                    REG_FREQ_HI: rd = {1'b0, r_length_en, 6'd0};
                    default:     rd = 8'd0;
                endcase
            end
            ACT_RAM_RD: begin
                rd = ram_byte;
            end
            default: begin
            end
        endcase

        // The level is refreshed only by ticks.
        if (r_in.action == ACT_TICK) begin
            n_out_level = r_chan_en ? level_prod[5:2] : 4'd0;
        end

        n_out.read_data  = rd;
        n_out.sample     = n_out_level;
        n_out.channel_on = n_chan_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.payload;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RAM_BYTES; i++) begin
                r_wave_ram[RAM_AW'(i)] <= 8'd0;
            end
        end else if (step && r_in.action == ACT_RAM_WR) begin
            r_wave_ram[r_in.addr[RAM_AW-1:0]] <= r_in.write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_bank     <= 1'b0;
            r_bank_sel     <= 1'b0;
            r_dac_on       <= 1'b0;
            r_length_count <= 8'd0;
            r_volume       <= 3'd0;
            r_freq         <= 11'd0;
            r_length_en    <= 1'b0;
            r_chan_en      <= 1'b0;
            r_out_level    <= 4'd0;
            r_sample_pos   <= '0;
            r_play_bank    <= 1'b0;
            r_held_sample  <= 4'd0;
            r_period       <= 12'd0;
        end else if (step) begin
            r_two_bank     <= n_two_bank;
            r_bank_sel     <= n_bank_sel;
            r_dac_on       <= n_dac_on;
            r_length_count <= n_length_count;
            r_volume       <= n_volume;
            r_freq         <= n_freq;
            r_length_en    <= n_length_en;
            r_chan_en      <= n_chan_en;
            r_out_level    <= n_out_level;
            r_sample_pos   <= n_sample_pos;
            r_play_bank    <= n_play_bank;
            r_held_sample  <= n_held_sample;
            r_period       <= n_period;
        end
    end

endmodule

// ----- hdl/wtsc_checker.sv -----
// Port-level checker for the wave-table sound channel, bound to the top level.
`include "wave_table_sound_channel_unit_defines.svh"

module wtsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_read_data,
    input logic [3:0] i_out_sample,
    input logic       i_out_channel_on
);

    logic [2:0] r_outstanding, n_outstanding;

    // Beats taken in but not yet delivered; the design holds at most two.
    always_comb begin
        n_outstanding = r_outstanding;
        if (i_in_valid && i_in_ready) begin
            n_outstanding = n_outstanding + 3'd1;
        end
        if (i_out_valid && i_out_ready) begin
            n_outstanding = n_outstanding - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= 3'd0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    `WTSC_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result beat dropped while stalled")
    `WTSC_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable({i_out_read_data, i_out_sample, i_out_channel_on}), "stalled result beat changed")
    `WTSC_ASSERT(a_no_invented, i_out_valid |-> r_outstanding != 3'd0, "result beat without an accepted input beat")
    `WTSC_ASSERT(a_depth, r_outstanding <= 3'd2, "more beats in flight than the two registers hold")
    `WTSC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !i_out_valid, "result offered right after reset")

endmodule

bind wave_table_sound_channel_unit wtsc_checker u_wtsc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_item.valid),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_out_read_data  (o_result.payload.read_data),
    .i_out_sample     (o_result.payload.sample),
    .i_out_channel_on (o_result.payload.channel_on)
);
